FILE: rtl/lfu_pkg.sv
`timescale 1ns / 1ps
package lfu_pkg;

   localparam int MAX_ENTRIES = 16;
   localparam int COUNT_BITS  = 16;
   localparam int KEY_W       = 31;
   localparam int STAMP_W     = 48;
   localparam int CAP_W       = 5;
   localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int OCC_W       = $clog2(MAX_ENTRIES + 1);
   localparam int CMP_W       = (CAP_W > OCC_W) ? CAP_W : OCC_W;
   localparam int REQ_DATA_W  = 64;
   localparam int RSP_DATA_W  = 32;

   localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

   localparam logic KIND_GET = 1'b0;
   localparam logic KIND_PUT = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_COMMIT
   } state_type;

   // running result handed from cell to cell
   typedef struct packed {
      logic                  valid;
      logic                  hit;
      logic [IDX_W-1:0]      hit_idx;
      logic [KEY_W-1:0]      hit_value;
      logic                  free;
      logic [IDX_W-1:0]      free_idx;
      logic                  victim;
      logic [IDX_W-1:0]      victim_idx;
      logic [COUNT_BITS-1:0] victim_count;
      logic [STAMP_W-1:0]    victim_stamp;
   } scan_rec_type;

   // broadcast update, applied by the selected cell
   typedef struct packed {
      logic               fill;
      logic               put;
      logic [KEY_W-1:0]   key;
      logic [KEY_W-1:0]   value;
      logic [STAMP_W-1:0] stamp;
   } upd_cmd_type;

endpackage

FILE: rtl/lfu_cell.sv
`timescale 1ns / 1ps
module lfu_cell (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [lfu_pkg::IDX_W-1:0]   cell_index,
   input  logic [lfu_pkg::KEY_W-1:0]   lookup_key,
   input  lfu_pkg::scan_rec_type       rec_in,
   output lfu_pkg::scan_rec_type       rec_out,
   input  logic                        wr_sel,
   input  lfu_pkg::upd_cmd_type        cmd
);

   logic                             valid_ff;
   logic [lfu_pkg::KEY_W-1:0]        key_ff;
   logic [lfu_pkg::KEY_W-1:0]        value_ff;
   logic [lfu_pkg::COUNT_BITS-1:0]   count_ff;
   logic [lfu_pkg::STAMP_W-1:0]      stamp_ff;
   lfu_pkg::scan_rec_type            rec_ff;
   lfu_pkg::scan_rec_type            rec_in_next;
   logic                             older;

   always_comb begin
      rec_in_next = rec_in;
      older = !rec_in.victim
              || (count_ff < rec_in.victim_count)
              || ((count_ff == rec_in.victim_count) && (stamp_ff < rec_in.victim_stamp));
      if (valid_ff) begin
         if (!rec_in.hit && (key_ff == lookup_key)) begin
            rec_in_next.hit       = 1'b1;
            rec_in_next.hit_idx   = cell_index;
            rec_in_next.hit_value = value_ff;
         end
         if (older) begin
            rec_in_next.victim       = 1'b1;
            rec_in_next.victim_idx   = cell_index;
            rec_in_next.victim_count = count_ff;
            rec_in_next.victim_stamp = stamp_ff;
         end
      end else if (!rec_in.free) begin
         rec_in_next.free     = 1'b1;
         rec_in_next.free_idx = cell_index;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rec_ff <= '0;
      end else begin
         rec_ff <= rec_in_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (wr_sel && cmd.fill) begin
         valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_sel) begin
         stamp_ff <= cmd.stamp;
         if (cmd.fill) begin
            key_ff   <= cmd.key;
            value_ff <= cmd.value;
            count_ff <= lfu_pkg::COUNT_BITS'(1);
         end else begin
            if (count_ff != {lfu_pkg::COUNT_BITS{1'b1}}) begin
               count_ff <= count_ff + lfu_pkg::COUNT_BITS'(1);
            end
            if (cmd.put) begin
               value_ff <= cmd.value;
            end
         end
      end
   end

   assign rec_out = rec_ff;

endmodule

FILE: rtl/lfu_cache_lru_tiebreak.sv
`timescale 1ns / 1ps
// LFU key/value cache, 16 entries, lowest use count evicted, oldest first on ties.
// Request channel (req_): tuser is the kind (0 get, 1 put), tdata carries key and value.
// Response channel (rsp_): tuser is the found flag, tdata the value read on a get hit.
// One response per request, in order.
// Each entry lives in one cell of a row; a lookup record walks the row one cell
// per cycle, collecting the matching entry, the first free slot and the victim.
// A request is registered, then its record passes the register of each cell in
// turn, is latched into the result register, and the commit writes the response.
// Requests do not overlap: req_tready rises only with the response, and the
// next request is taken at the following edge, while that response may still
// be waiting.
// The single output register holds a response while rsp_tready is low; the
// commit waits until it is free, so no response is lost.
// csr_wr_en/csr_wr_data set the capacity (0 acts as 1, above 16 as 16); write
// only while idle.
// Reset (synchronous): all entries invalid, capacity 16, stamp counter and
// occupancy zero, no response pending.
module lfu_cache_lru_tiebreak (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [lfu_pkg::REQ_DATA_W-1:0]  req_tdata,   // key[30:0], value[61:31], zero
   input  logic                            req_tuser,   // kind
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [lfu_pkg::RSP_DATA_W-1:0]  rsp_tdata,   // read_value[30:0], zero
   output logic                            rsp_tuser,   // found
   input  logic                            csr_wr_en,
   input  logic [lfu_pkg::CAP_W-1:0]       csr_wr_data
);

   localparam int IDX_W = lfu_pkg::IDX_W;
   localparam int KEY_W = lfu_pkg::KEY_W;
   localparam int NCELL = lfu_pkg::MAX_ENTRIES;

   lfu_pkg::state_type                state_ff, state_in;
   logic                              kind_ff;
   logic [KEY_W-1:0]                  key_ff;
   logic [KEY_W-1:0]                  value_ff;
   logic                              start_ff;
   lfu_pkg::scan_rec_type             res_ff;
   logic [lfu_pkg::STAMP_W-1:0]       stamp_ff;
   logic [lfu_pkg::OCC_W-1:0]         in_use_ff;
   logic [lfu_pkg::CAP_W-1:0]         cap_ff;
   logic                              rsp_valid_ff;
   logic                              rsp_found_ff;
   logic [KEY_W-1:0]                  rsp_value_ff;

   lfu_pkg::scan_rec_type             rec_chain [NCELL+1];
   logic [NCELL-1:0]                  rec_valid_vec;
   logic [NCELL-1:0]                  wr_sel;
   lfu_pkg::upd_cmd_type              cmd;
   logic                              accept;
   logic                              rsp_free;
   logic                              commit_go;
   logic                              upd_en;
   logic                              take_free;
   logic [IDX_W-1:0]                  slot;
   logic [lfu_pkg::CMP_W-1:0]         eff_cap;
   logic                              full;

   assign accept   = req_tvalid && req_tready;
   assign rsp_free = !rsp_valid_ff || rsp_tready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         lfu_pkg::ST_IDLE: begin
            if (accept) state_in = lfu_pkg::ST_SCAN;
         end
         lfu_pkg::ST_SCAN: begin
            if (rec_chain[NCELL].valid) state_in = lfu_pkg::ST_COMMIT;
         end
         lfu_pkg::ST_COMMIT: begin
            if (rsp_free) state_in = lfu_pkg::ST_IDLE;
         end
         default: state_in = lfu_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_tready = 1'b0;
      commit_go  = 1'b0;
      case (state_ff)
         lfu_pkg::ST_IDLE:   req_tready = 1'b1;
         lfu_pkg::ST_SCAN:   req_tready = 1'b0;
         lfu_pkg::ST_COMMIT: commit_go  = rsp_free;
         default: begin
            req_tready = 1'b0;
            commit_go  = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lfu_pkg::ST_IDLE;
         start_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         start_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff  <= req_tuser;
         key_ff   <= req_tdata[KEY_W-1:0];
         value_ff <= req_tdata[2*KEY_W-1:KEY_W];
      end
      if (rec_chain[NCELL].valid) begin
         res_ff <= rec_chain[NCELL];
      end
   end

   // replacement choice
   always_comb begin
      if (cap_ff == '0) begin
         eff_cap = lfu_pkg::CMP_W'(1);
      end else if (lfu_pkg::CMP_W'(cap_ff) > lfu_pkg::CMP_W'(NCELL)) begin
         eff_cap = lfu_pkg::CMP_W'(NCELL);
      end else begin
         eff_cap = lfu_pkg::CMP_W'(cap_ff);
      end
      full      = lfu_pkg::CMP_W'(in_use_ff) >= eff_cap;
      take_free = 1'b0;
      slot      = res_ff.victim_idx;
      upd_en    = 1'b0;
      if (res_ff.hit) begin
         upd_en = 1'b1;
         slot   = res_ff.hit_idx;
      end else if (kind_ff == lfu_pkg::KIND_PUT) begin
         upd_en = 1'b1;
         if (full && res_ff.victim) begin
            slot = res_ff.victim_idx;
         end else if (res_ff.free) begin
            slot      = res_ff.free_idx;
            take_free = 1'b1;
         end
      end
      cmd.fill  = !res_ff.hit;
      cmd.put   = kind_ff;
      cmd.key   = key_ff;
      cmd.value = value_ff;
      cmd.stamp = stamp_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stamp_ff  <= '0;
         in_use_ff <= '0;
         cap_ff    <= lfu_pkg::CAP_RESET;
      end else begin
         if (commit_go && upd_en) begin
            stamp_ff <= stamp_ff + lfu_pkg::STAMP_W'(1);
         end
         if (commit_go && take_free) begin
            in_use_ff <= in_use_ff + lfu_pkg::OCC_W'(1);
         end
         if (csr_wr_en) begin
            cap_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (commit_go) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (commit_go) begin
         rsp_found_ff <= res_ff.hit;
         rsp_value_ff <= (res_ff.hit && (kind_ff == lfu_pkg::KIND_GET))
                         ? res_ff.hit_value : '0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_found_ff;
   assign rsp_tdata  = lfu_pkg::RSP_DATA_W'(rsp_value_ff);

   always_comb begin
      rec_chain[0]       = '0;
      rec_chain[0].valid = start_ff;
   end

   for (genvar i = 0; i < NCELL; i++) begin : g_cell
      assign wr_sel[i]        = commit_go && upd_en && (slot == IDX_W'(i));
      assign rec_valid_vec[i] = rec_chain[i+1].valid;

      lfu_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cell_index (IDX_W'(i)),
         .lookup_key (key_ff),
         .rec_in     (rec_chain[i]),
         .rec_out    (rec_chain[i+1]),
         .wr_sel     (wr_sel[i]),
         .cmd        (cmd)
      );
   end

`ifndef ASSERT_OFF
   a_one_record: assert property (@(posedge clock) disable iff (reset)
      $onehot0({rec_valid_vec, start_ff}))
      else $error("more than one lookup record in the cell row");

   a_occupancy: assert property (@(posedge clock) disable iff (reset)
      lfu_pkg::CMP_W'(in_use_ff) <= lfu_pkg::CMP_W'(NCELL))
      else $error("occupancy above table size");

   a_record_in_scan: assert property (@(posedge clock) disable iff (reset)
      rec_chain[NCELL].valid |-> (state_ff == lfu_pkg::ST_SCAN))
      else $error("lookup record finished outside a scan");

   a_accept_scan: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == lfu_pkg::ST_SCAN) && start_ff)
      else $error("accepted request did not start a scan");

   a_single_write: assert property (@(posedge clock) disable iff (reset)
      $onehot0(wr_sel))
      else $error("update selects more than one cell");
`endif

endmodule

FILE: test/lfu_cache_lru_tiebreak_test.sv
`timescale 1ns / 1ps
module lfu_cache_lru_tiebreak_test;

   localparam int STALL_LIMIT = 4000;
   localparam int KEY_POOL    = 24;
   localparam int SAT_HITS    = 20;

   typedef struct packed {
      logic                      found;
      logic [lfu_pkg::KEY_W-1:0] read_value;
   } cache_reply_type;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [lfu_pkg::REQ_DATA_W-1:0] req_tdata = '0;
   logic                           req_tuser = lfu_pkg::KIND_GET;
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   logic [lfu_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic                           rsp_tuser;
   logic                           csr_wr_en = 1'b0;
   logic [lfu_pkg::CAP_W-1:0]      csr_wr_data = '0;

   lfu_cache_lru_tiebreak u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // cache model state
   logic                           slot_valid [lfu_pkg::MAX_ENTRIES];
   logic [lfu_pkg::KEY_W-1:0]      slot_key   [lfu_pkg::MAX_ENTRIES];
   logic [lfu_pkg::KEY_W-1:0]      slot_value [lfu_pkg::MAX_ENTRIES];
   logic [lfu_pkg::COUNT_BITS-1:0] slot_uses  [lfu_pkg::MAX_ENTRIES];
   logic [lfu_pkg::STAMP_W-1:0]    slot_stamp [lfu_pkg::MAX_ENTRIES];
   logic [lfu_pkg::STAMP_W-1:0]    stamp_now = '0;
   int                             occupancy = 0;
   logic [lfu_pkg::CAP_W-1:0]      capacity = lfu_pkg::CAP_RESET;

   cache_reply_type                pending_replies[$];
   logic [lfu_pkg::KEY_W-1:0]      key_pool[KEY_POOL];
   int                             send_idle_pct = 0;
   int                             rsp_stall_pct = 0;
   int                             mismatch_count = 0;
   int                             idle_cycles = 0;

   initial begin
      for (int i = 0; i < lfu_pkg::MAX_ENTRIES; i++) begin
         slot_valid[i] = 1'b0;
         slot_key[i]   = '0;
         slot_value[i] = '0;
         slot_uses[i]  = '0;
         slot_stamp[i] = '0;
      end
   end

   function automatic cache_reply_type cache_apply(logic kind,
                                                   logic [lfu_pkg::KEY_W-1:0] key,
                                                   logic [lfu_pkg::KEY_W-1:0] value);
      int              hit_slot;
      int              free_slot;
      int              victim_slot;
      int              slot;
      int              eff_cap;
      cache_reply_type reply;
      hit_slot    = -1;
      free_slot   = -1;
      victim_slot = -1;
      reply       = '0;
      for (int i = 0; i < lfu_pkg::MAX_ENTRIES; i++) begin
         if (slot_valid[i]) begin
            if (hit_slot < 0 && slot_key[i] == key) hit_slot = i;
            if (victim_slot < 0 || slot_uses[i] < slot_uses[victim_slot] ||
                (slot_uses[i] == slot_uses[victim_slot] &&
                 slot_stamp[i] < slot_stamp[victim_slot]))
               victim_slot = i;
         end else if (free_slot < 0) begin
            free_slot = i;
         end
      end
      if (hit_slot >= 0) begin
         if (slot_uses[hit_slot] != '1)
            slot_uses[hit_slot] = slot_uses[hit_slot] + lfu_pkg::COUNT_BITS'(1);
         slot_stamp[hit_slot] = stamp_now;
         stamp_now = stamp_now + lfu_pkg::STAMP_W'(1);
         reply.found = 1'b1;
         if (kind == lfu_pkg::KIND_GET) reply.read_value = slot_value[hit_slot];
         else slot_value[hit_slot] = value;
         return reply;
      end
      if (kind == lfu_pkg::KIND_PUT) begin
         eff_cap = (capacity == '0) ? 1 :
                   (int'(capacity) > lfu_pkg::MAX_ENTRIES) ? lfu_pkg::MAX_ENTRIES :
                   int'(capacity);
         if (occupancy >= eff_cap && victim_slot >= 0) begin
            slot = victim_slot;
         end else if (free_slot >= 0) begin
            slot = free_slot;
            occupancy++;
         end else begin
            slot = victim_slot;
         end
         slot_valid[slot] = 1'b1;
         slot_key[slot]   = key;
         slot_value[slot] = value;
         slot_uses[slot]  = lfu_pkg::COUNT_BITS'(1);
         slot_stamp[slot] = stamp_now;
         stamp_now = stamp_now + lfu_pkg::STAMP_W'(1);
      end
      return reply;
   endfunction

   always @(posedge clock) begin
      cache_reply_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (pending_replies.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("unexpected response: found=%0d data=%h", rsp_tuser, rsp_tdata);
            end else begin
               want = pending_replies.pop_front();
               if (rsp_tuser !== want.found || rsp_tdata !== {1'b0, want.read_value}) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("mismatch: expected found=%0d value=%h, got found=%0d data=%h",
                              want.found, want.read_value, rsp_tuser, rsp_tdata);
               end
            end
         end
         rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   task automatic send_request(logic kind, logic [lfu_pkg::KEY_W-1:0] key,
                               logic [lfu_pkg::KEY_W-1:0] value);
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {2'b00, value, key};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_replies.push_back(cache_apply(kind, key, value));
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (pending_replies.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_capacity(logic [lfu_pkg::CAP_W-1:0] cap);
      wait_drained();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= cap;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      capacity = cap;
   endtask

   task automatic test_directed_basics();
      send_request(lfu_pkg::KIND_GET, '0, '1);
      send_request(lfu_pkg::KIND_PUT, '0, '1);
      send_request(lfu_pkg::KIND_GET, '0, '0);
      send_request(lfu_pkg::KIND_PUT, '1, '0);
      send_request(lfu_pkg::KIND_GET, '1, '1);
      send_request(lfu_pkg::KIND_PUT, '0, 31'h2AAA_AAAA);
      send_request(lfu_pkg::KIND_GET, '0, '0);
      send_request(lfu_pkg::KIND_GET, 31'h5555_5555, '0);
   endtask

   task automatic test_eviction_order();
      write_capacity(5'd3);
      send_request(lfu_pkg::KIND_PUT, 31'd100, 31'd1);
      send_request(lfu_pkg::KIND_PUT, 31'd200, 31'd2);
      send_request(lfu_pkg::KIND_GET, '1, '0);
      send_request(lfu_pkg::KIND_PUT, 31'd300, 31'd3);
      send_request(lfu_pkg::KIND_GET, 31'd100, '0);
      send_request(lfu_pkg::KIND_GET, 31'd200, '0);
      send_request(lfu_pkg::KIND_GET, 31'd300, '0);
   endtask

   task automatic test_capacity_clamp();
      write_capacity(5'd0);
      send_request(lfu_pkg::KIND_PUT, 31'd400, 31'd4);
      send_request(lfu_pkg::KIND_PUT, 31'd500, 31'd5);
      send_request(lfu_pkg::KIND_GET, 31'd400, '0);
      write_capacity(5'd31);
      send_request(lfu_pkg::KIND_PUT, 31'd600, 31'd6);
      send_request(lfu_pkg::KIND_GET, 31'd500, '0);
      send_request(lfu_pkg::KIND_GET, 31'd600, '0);
   endtask

   // raise one entry's use count well above the rest, then force evictions
   task automatic test_count_saturation();
      logic [lfu_pkg::KEY_W-1:0] hot_key;
      hot_key = 31'h1234_5678;
      write_capacity(5'd1);
      write_capacity(5'd2);
      send_request(lfu_pkg::KIND_PUT, hot_key, 31'h0BAD_CAFE);
      for (int i = 0; i < SAT_HITS; i++) send_request(lfu_pkg::KIND_GET, hot_key, '0);
      send_request(lfu_pkg::KIND_PUT, 31'd700, 31'd7);
      send_request(lfu_pkg::KIND_PUT, 31'd800, 31'd8);
      send_request(lfu_pkg::KIND_GET, hot_key, '0);
   endtask

   task automatic run_random_phase(logic [lfu_pkg::CAP_W-1:0] cap, int send_idle, int stall,
                                   int num_requests);
      logic                      kind;
      logic [lfu_pkg::KEY_W-1:0] key;
      logic [lfu_pkg::KEY_W-1:0] value;
      write_capacity(cap);
      send_idle_pct = send_idle;
      rsp_stall_pct = stall;
      for (int n = 0; n < num_requests; n++) begin
         kind = 1'($urandom_range(1));
         if ($urandom_range(99) < 85) key = key_pool[$urandom_range(KEY_POOL - 1)];
         else key = lfu_pkg::KEY_W'($urandom);
         case ($urandom_range(19))
            0:       value = '0;
            1:       value = '1;
            default: value = lfu_pkg::KEY_W'($urandom);
         endcase
         send_request(kind, key, value);
         if (n == num_requests / 2 || $urandom_range(99) == 0) wait_drained();
      end
   endtask

   task automatic test_random_traffic();
      for (int i = 0; i < KEY_POOL; i++) key_pool[i] = lfu_pkg::KEY_W'($urandom);
      key_pool[0] = '0;
      key_pool[1] = '1;
      run_random_phase(5'd16, 0, 0, 250);
      run_random_phase(5'd4, 88, 0, 250);
      run_random_phase(5'd9, 0, 88, 250);
      run_random_phase(5'd1, 30, 30, 250);
      run_random_phase(5'd31, 0, 0, 250);
      run_random_phase(5'd2, 30, 30, 250);
      send_idle_pct = 0;
      rsp_stall_pct = 0;
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_basics();
      test_eviction_order();
      test_capacity_clamp();
      test_count_saturation();
      test_random_traffic();
      wait_drained();
      repeat (25) @(posedge clock);
      if (mismatch_count == 0 && pending_replies.size() == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
